// ===== src/sr_pkg.sv =====
// Package: widths, constants and codes shared by the systematic resampler files.
`default_nettype none

package sr_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int FRAC_BITS     = 16;

  localparam int IDX_W     = $clog2(MAX_PARTICLES);
  localparam int CNT_W     = $clog2(MAX_PARTICLES + 1);
  localparam int PC_W      = 7;
  localparam int CUM_W     = FRAC_BITS + 7;
  localparam int PT_W      = FRAC_BITS + 2;
  localparam int WGT_W     = FRAC_BITS + 1;
  localparam int OFS_W     = FRAC_BITS;
  localparam int STR_W     = FRAC_BITS + 1;
  localparam int CFG_W     = (STR_W > PC_W) ? STR_W : PC_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [STR_W-1:0] ONE_FX       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CUM_W-1:0] CUM_MAX      = {CUM_W{1'b1}};
  localparam logic [PC_W-1:0]  PC_RESET     = PC_W'(64);
  localparam logic [STR_W-1:0] STRIDE_RESET = STR_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE         = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

endpackage

`default_nettype wire

// ===== src/sr_if.sv =====
// Interfaces: request channel (load or draw) and result channel (source indices).
`default_nettype none

interface sr_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [sr_pkg::WGT_W-1:0]   weight;
  logic [sr_pkg::OFS_W-1:0]   random_offset;

  modport source (output valid, output op, output weight, output random_offset, input ready);
  modport sink   (input valid, input op, input weight, input random_offset, output ready);
endinterface

interface sr_res_if;
  logic                       valid;
  logic                       ready;
  logic [sr_pkg::IDX_W-1:0]   source_index;
  logic                       last;

  modport source (output valid, output source_index, output last, input ready);
  modport sink   (input valid, input source_index, input last, output ready);
endinterface

`default_nettype wire

// ===== src/systematic_resampler_top.sv =====
// Top level: systematic resampler with cumulative weight memory and comb search.
//
//  channel | dir | payload                      | accepted when
//  --------+-----+------------------------------+-----------------------------
//  req     | in  | op, weight, random_offset    | req.valid && req.ready
//  res     | out | source_index, last           | res.valid && res.ready
//  cfg     | in  | cfg_idx_i, cfg_data_i        | cfg_we_i
//
// A load writes the saturated running sum into the memory.
// A draw is paced by the single read port of the cumulative memory: each comb
// point does a binary search over the current round's entries, one read per cycle,
// plus a linear scan over stale entries when the search finds no hit.
// Reset clears counters, sums and the FSM; the memory is not cleared.
// A waiting result holds the walk at its next emit; requests wait until the draw ends.
`default_nettype none

module systematic_resampler_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sr_req_if.sink                             req,
  sr_res_if.source                           res,
  input  wire logic                          cfg_we_i,
  input  wire logic [sr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sr_pkg::CFG_W-1:0]      cfg_data_i
);
  import sr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_BIN,
    S_LIN,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [PC_W-1:0]   pcnt_q, pcnt_d;
  logic [STR_W-1:0]  stride_q, stride_d;
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic [CUM_W-1:0]  sum_q, sum_d;
  logic [PT_W-1:0]   pt_q, pt_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  lim_q, lim_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  pidx_q, pidx_d;
  logic [IDX_W-1:0]  sel_q, sel_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;

  logic [CUM_W-1:0]  mem_q [MAX_PARTICLES];
  logic [CUM_W-1:0]  rdata_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CUM_W-1:0]  wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  logic [CNT_W-1:0]  n_eff;
  logic [STR_W-1:0]  step;
  logic [CUM_W:0]    sum_ext;
  logic              req_acc;
  logic              gt;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid_cur;
  logic [CNT_W-1:0]  lo_n, hi_n;
  logic [CNT_W:0]    mid_sum_n;
  logic [CNT_W-1:0]  mid_n;
  logic [PT_W-1:0]   pt_add;
  logic              emit_ok;

  always_comb begin
    if (pcnt_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (pcnt_q > PC_W'(MAX_PARTICLES)) begin
      n_eff = CNT_W'(MAX_PARTICLES);
    end else begin
      n_eff = pcnt_q[CNT_W-1:0];
    end
  end

  assign step      = (stride_q > ONE_FX) ? ONE_FX : stride_q;
  assign req_acc   = req.valid && req.ready;
  assign sum_ext   = {1'b0, sum_q} + {{(CUM_W+1-WGT_W){1'b0}}, req.weight};
  assign gt        = rdata_q > {{(CUM_W-PT_W){1'b0}}, pt_q};
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_cur   = mid_sum[CNT_W:1];
  assign lo_n      = gt ? lo_q : mid_cur + CNT_W'(1);
  assign hi_n      = gt ? mid_cur : hi_q;
  assign mid_sum_n = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n     = mid_sum_n[CNT_W:1];
  assign pt_add    = pt_q + {{(PT_W-STR_W){1'b0}}, step};
  assign emit_ok   = !out_valid_q || res.ready;

  assign req.ready        = (state_q == S_IDLE);
  assign res.valid        = out_valid_q;
  assign res.source_index = out_idx_q;
  assign res.last         = out_last_q;

  always_comb begin
    state_d     = state_q;
    pcnt_d      = pcnt_q;
    stride_d    = stride_q;
    loaded_d    = loaded_q;
    sum_d       = sum_q;
    pt_d        = pt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    lim_d       = lim_q;
    n_d         = n_q;
    pidx_d      = pidx_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    wr_en       = 1'b0;
    wr_addr     = loaded_q[IDX_W-1:0];
    wr_data     = sum_ext[CUM_W] ? CUM_MAX : sum_ext[CUM_W-1:0];
    rd_en       = 1'b0;
    rd_addr     = mid_cur[IDX_W-1:0];

    if (out_valid_q && res.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PARTICLE_COUNT: pcnt_d   = cfg_data_i[PC_W-1:0];
        REG_STRIDE:         stride_d = cfg_data_i[STR_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          if (req.op == OP_LOAD) begin
            // drop loads beyond the particle count
            if (loaded_q < n_eff) begin
              wr_en    = 1'b1;
              sum_d    = wr_data;
              loaded_d = loaded_q + CNT_W'(1);
            end
          end else begin
            pt_d     = {{(PT_W-OFS_W){1'b0}}, req.random_offset};
            pidx_d   = '0;
            n_d      = n_eff;
            lim_d    = (loaded_q < n_eff) ? loaded_q : n_eff;
            loaded_d = '0;
            sum_d    = '0;
            state_d  = S_START;
          end
        end
      end
      S_START: begin
        lo_d = '0;
        hi_d = lim_q;
        k_d  = lim_q;
        if (lim_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = lim_q[CNT_W-1:1];
          state_d = S_BIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = S_LIN;
        end
      end
      S_BIN: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          rd_en   = 1'b1;
          rd_addr = mid_n[IDX_W-1:0];
        end else if (lo_n < lim_q) begin
          sel_d   = lo_n[IDX_W-1:0];
          state_d = S_EMIT;
        end else if (lim_q < n_q) begin
          // no hit in this round's entries: scan the stale ones
          rd_en   = 1'b1;
          rd_addr = lim_q[IDX_W-1:0];
          k_d     = lim_q;
          state_d = S_LIN;
        end else begin
          sel_d   = IDX_W'(n_q - CNT_W'(1));
          state_d = S_EMIT;
        end
      end
      S_LIN: begin
        if (gt) begin
          sel_d   = k_q[IDX_W-1:0];
          state_d = S_EMIT;
        end else if (k_q == n_q - CNT_W'(1)) begin
          sel_d   = IDX_W'(n_q - CNT_W'(1));
          state_d = S_EMIT;
        end else begin
          k_d     = k_q + CNT_W'(1);
          rd_en   = 1'b1;
          rd_addr = k_d[IDX_W-1:0];
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_idx_d   = sel_q;
          out_last_d  = (pidx_q == n_q - CNT_W'(1));
          if (pidx_q == n_q - CNT_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            // advance the comb point, wrap down by one above 1.0
            pidx_d  = pidx_q + CNT_W'(1);
            pt_d    = (pt_add > {{(PT_W-STR_W){1'b0}}, ONE_FX})
                      ? pt_add - {{(PT_W-STR_W){1'b0}}, ONE_FX} : pt_add;
            state_d = S_START;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pcnt_q      <= PC_RESET;
      stride_q    <= STRIDE_RESET;
      loaded_q    <= '0;
      sum_q       <= '0;
      pt_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      lim_q       <= '0;
      n_q         <= CNT_W'(1);
      pidx_q      <= '0;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pcnt_q      <= pcnt_d;
      stride_q    <= stride_d;
      loaded_q    <= loaded_d;
      sum_q       <= sum_d;
      pt_q        <= pt_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      k_q         <= k_d;
      lim_q       <= lim_d;
      n_q         <= n_d;
      pidx_q      <= pidx_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_last_q  <= out_last_d;
    end
  end

`ifndef SYNTH
  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BIN) |-> (lo_q < hi_q) && (hi_q <= lim_q))
    else $error("binary search bounds out of order");

  a_lin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIN) |-> (k_q >= lim_q) && (k_q < n_q))
    else $error("stale scan address out of range");

  a_point_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_q <= {{(PT_W-STR_W){1'b0}}, ONE_FX})
    else $error("comb point above 1.0");

  a_draw_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req.op == OP_DRAW) |=> (loaded_q == '0) && (sum_q == '0))
    else $error("draw did not clear load bookkeeping");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && emit_ok && pidx_q == n_q - CNT_W'(1))
      |=> out_valid_q && out_last_q && state_q == S_IDLE)
    else $error("final index not flagged last");
`endif

endmodule

`default_nettype wire

// ===== tb/systematic_resampler_top_test.sv =====
// Testbench for the systematic resampler: directed table, then randomised rounds.
module systematic_resampler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sr_pkg::*;

  localparam int RANDOM_ITEMS    = 95;
  localparam int DRAIN_CYCLES    = 16;
  localparam int TAIL_CYCLES     = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TIMEOUT_NS      = 2_000_000;

  typedef struct packed {
    logic [IDX_W-1:0] source_index;
    logic             last;
  } index_result_t;

  typedef enum logic [1:0] {ROW_COUNT, ROW_STRIDE, ROW_LOAD, ROW_DRAW} row_kind_e;
  typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_PERIODIC} sink_mode_e;

  // exp_cnt of zero: take the expected indices from the predictor
  typedef struct packed {
    row_kind_e        kind;
    logic [CFG_W-1:0] value;
    logic [6:0]       exp_cnt;
    logic [IDX_W-1:0] exp_idx;
  } directed_row_t;

  localparam directed_row_t DIRECTED [22] = '{
    '{ROW_COUNT,  17'd0,       7'd0, 6'd0},  // zero particles count as one
    '{ROW_LOAD,   17'h10000,   7'd0, 6'd0},
    '{ROW_LOAD,   17'd5,       7'd0, 6'd0},  // beyond the count: dropped
    '{ROW_DRAW,   17'h0FFFF,   7'd1, 6'd0},
    '{ROW_COUNT,  17'd2,       7'd0, 6'd0},
    '{ROW_LOAD,   17'd0,       7'd0, 6'd0},
    '{ROW_LOAD,   17'h10000,   7'd0, 6'd0},
    '{ROW_DRAW,   17'd0,       7'd2, 6'd1},
    '{ROW_STRIDE, 17'h1FFFF,   7'd0, 6'd0},  // stride above one is capped
    '{ROW_LOAD,   17'd1,       7'd0, 6'd0},
    '{ROW_LOAD,   17'd1,       7'd0, 6'd0},
    '{ROW_DRAW,   17'h0FFFF,   7'd2, 6'd1},  // every point beyond the total
    '{ROW_COUNT,  17'd4,       7'd0, 6'd0},
    '{ROW_LOAD,   17'h1FFFF,   7'd0, 6'd0},
    '{ROW_LOAD,   17'h1FFFF,   7'd0, 6'd0},
    '{ROW_LOAD,   17'h1FFFF,   7'd0, 6'd0},
    '{ROW_LOAD,   17'h1FFFF,   7'd0, 6'd0},
    '{ROW_DRAW,   17'h08000,   7'd0, 6'd0},
    '{ROW_STRIDE, 17'd1,       7'd0, 6'd0},
    '{ROW_LOAD,   17'h04000,   7'd0, 6'd0},
    '{ROW_LOAD,   17'h04000,   7'd0, 6'd0},
    '{ROW_DRAW,   17'h07FFF,   7'd0, 6'd0}   // short round: stale upper slots
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  sr_req_if req_ch ();
  sr_res_if res_ch ();

  systematic_resampler_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .res        (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic [CUM_W-1:0] cum_copy [MAX_PARTICLES];
  int unsigned      loaded_copy = 0;
  int unsigned      sum_copy    = 0;
  int unsigned      point_copy  = 0;
  logic [PC_W-1:0]  pc_copy     = PC_RESET;
  logic [STR_W-1:0] stride_copy = STRIDE_RESET;
  index_result_t    comb_out [MAX_PARTICLES];

  index_result_t pending_indices [$];
  int            error_count = 0;
  int            items_sent  = 0;
  int            burst_left  = 0;
  bit            hold_off_pending = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int active_count(input logic [PC_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > MAX_PARTICLES) return MAX_PARTICLES;
    return int'(cnt);
  endfunction

  // Advance the model by one request; a draw leaves its indices in comb_out.
  function automatic int resample_predict(input logic op, input logic [WGT_W-1:0] w,
                                          input logic [OFS_W-1:0] ofs);
    int unsigned n, s, step, p, k;
    n = active_count(pc_copy);
    if (op == OP_LOAD) begin
      if (loaded_copy >= n) return 0;
      s = sum_copy + w;
      if (s > CUM_MAX) s = CUM_MAX;
      sum_copy = s;
      cum_copy[loaded_copy % MAX_PARTICLES] = CUM_W'(s);
      loaded_copy++;
      return 0;
    end
    step = (stride_copy > ONE_FX) ? ONE_FX : stride_copy;
    p = ofs;
    for (int i = 0; i < n; i++) begin
      if (i > 0) p += step;
      if (p > ONE_FX) p -= ONE_FX;
      p &= (1 << PT_W) - 1;
      k = 0;
      while (k < n - 1 && cum_copy[k] <= p) k++;
      comb_out[i].source_index = IDX_W'(k);
      comb_out[i].last = (i == n - 1);
    end
    point_copy = p;
    loaded_copy = 0;
    sum_copy = 0;
    return n;
  endfunction

  // Append one expected index to the scoreboard queue.
  task automatic expect_index(input index_result_t r);
    pending_indices = {pending_indices, r};
  endtask

  task automatic offer(input logic op, input logic [WGT_W-1:0] w, input logic [OFS_W-1:0] ofs,
                       input int typed_cnt, input logic [IDX_W-1:0] typed_idx);
    int gap, got;
    index_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.weight        <= w;
    req_ch.random_offset <= ofs;
    do @(posedge clk_i); while (!req_ch.ready);
    got = resample_predict(op, w, ofs);
    if (typed_cnt > 0) begin
      for (int i = 0; i < typed_cnt; i++) begin
        r.source_index = typed_idx;
        r.last = (i == typed_cnt - 1);
        expect_index(r);
      end
    end else begin
      for (int i = 0; i < got; i++) expect_index(comb_out[i]);
    end
  endtask

  // Drop valid and wait until every expected index has arrived.
  task automatic settle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_indices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_PARTICLE_COUNT) pc_copy = data[PC_W-1:0];
    else stride_copy = data[STR_W-1:0];
  endtask

  task automatic run_round(input int n, input bit broken_ok, input bit force_short);
    int loads, roll, extra, w_max;
    roll = $urandom_range(0, 9);
    loads = n;
    if (force_short) loads = $urandom_range(0, (n > 8) ? 8 : n - 1);
    else if (broken_ok && roll == 0) loads = $urandom_range(0, n - 1);
    extra = (loads == n && roll == 1) ? $urandom_range(1, 2) : 0;
    w_max = (2 * 65536) / n;
    if (w_max > 'h1FFFF) w_max = 'h1FFFF;
    for (int i = 0; i < loads + extra; i++) begin
      offer(OP_LOAD,
            WGT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 'h1FFFF)
                                                : $urandom_range(0, w_max)),
            OFS_W'($urandom), 0, '0);
      if (i < loads) items_sent++;
    end
    offer(OP_DRAW, WGT_W'($urandom), OFS_W'($urandom_range(0, 'hFFFF)), 0, '0);
    items_sent++;
  endtask

  initial begin : stimulus
    int n, rounds;
    logic [PC_W-1:0]  count_val;
    logic [STR_W-1:0] stride_val;
    foreach (cum_copy[i]) cum_copy[i] = '0;
    rst_ni               <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.op            <= OP_LOAD;
    req_ch.weight        <= '0;
    req_ch.random_offset <= '0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= REG_PARTICLE_COUNT;
    cfg_data_i           <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int r = 0; r < $size(DIRECTED); r++) begin
      case (DIRECTED[r].kind)
        ROW_COUNT:  write_register(REG_PARTICLE_COUNT, DIRECTED[r].value);
        ROW_STRIDE: write_register(REG_STRIDE, DIRECTED[r].value);
        ROW_LOAD:   offer(OP_LOAD, DIRECTED[r].value[WGT_W-1:0], '0,
                          DIRECTED[r].exp_cnt, DIRECTED[r].exp_idx);
        default:    offer(OP_DRAW, '0, DIRECTED[r].value[OFS_W-1:0],
                          DIRECTED[r].exp_cnt, DIRECTED[r].exp_idx);
      endcase
    end

    // The first phase fills every slot, so later short rounds only read written slots.
    for (int ph = 0; ph < 4 || items_sent < RANDOM_ITEMS; ph++) begin
      if (ph == 0) count_val = PC_W'(MAX_PARTICLES);
      else if (ph == 3) count_val = '1;
      else if ($urandom_range(0, 4) == 0) count_val = PC_W'($urandom_range(11, 24));
      else count_val = PC_W'($urandom_range(1, 10));
      n = active_count(count_val);
      case ($urandom_range(0, 4))
        0:       stride_val = STR_W'($urandom_range(0, 'h1FFFF));
        1:       stride_val = ONE_FX;
        default: stride_val = STR_W'(65536 / n + $urandom_range(0, 16));
      endcase
      write_register(REG_PARTICLE_COUNT, CFG_W'(count_val));
      write_register(REG_STRIDE, CFG_W'(stride_val));
      rounds = (n >= 32) ? 1 : (ph == 2) ? 2 : $urandom_range(1, 2);
      for (int rnd = 0; rnd < rounds; rnd++) begin
        if (ph == 2 && rnd == 0) hold_off_pending = 1'b1;
        run_round(n, ph > 0, ph == 3);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("systematic_resampler_top_test: clean");
    else $display("systematic_resampler_top_test: errors");
    $finish;
  end

  initial begin : result_sink
    sink_mode_e mode;
    int mode_left, hold_left, tick;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left == 0 && hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   res_ch.ready <= 1'b1;
          SINK_HALF:   res_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     res_ch.ready <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    index_result_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready) begin
      if (pending_indices.size() == 0) begin
        $error("unexpected result: source_index %0d last %0b",
               res_ch.source_index, res_ch.last);
        error_count++;
      end else begin
        want = pending_indices.pop_front();
        if (res_ch.source_index !== want.source_index) begin
          $error("source_index: expected %0d, got %0d", want.source_index,
                 res_ch.source_index);
          error_count++;
        end
        if (res_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_ch.last);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("systematic_resampler_top_test: errors");
    $finish;
  end

endmodule
